[rtl/drsc_pkg.sv]
// ----------------------------------------------------------------------------
// drsc_pkg
// Shared constants, types and helper functions of the depth/RGB scaler and
// compositor: source frame geometry, field widths, codes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package drsc_pkg;

  // Source frame geometry.
  localparam int SRC_WIDTH  = 640;
  localparam int SRC_HEIGHT = 480;
  localparam int SRC_PIXELS = SRC_WIDTH * SRC_HEIGHT;
  localparam int SRC_MAX    = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int ADDR_W     = $clog2(SRC_PIXELS);

  // Screen geometry.
  localparam int SCREEN_MAX = 4096;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;

  // Divider sizing: every quotient is below the source size.
  localparam int QW         = $clog2(SRC_MAX);
  localparam int DVD_W      = DIM_W + QW;
  localparam int DSH_W      = DIM_W + QW - 1;
  localparam int CNT_W      = $clog2(QW + 1);

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 19;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int ADR_W      = 26;
  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;
  localparam int CIDX_W     = 3;
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 64;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_DEPTH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RGB   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // Pixel output formats.
  localparam logic [MODE_W-1:0] MODE_BGRA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd1;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_SCREEN_W  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SCREEN_H  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MODE      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_OVERLAY_W = 3'd3;
  localparam logic [CIDX_W-1:0] REG_OVERLAY_H = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0] RST_SCREEN_W  = 13'd640;
  localparam logic [DIM_W-1:0] RST_SCREEN_H  = 13'd480;
  localparam logic [DIM_W-1:0] RST_OVERLAY_W = 13'd480;
  localparam logic [DIM_W-1:0] RST_OVERLAY_H = 13'd360;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   pixel_index;
    logic [DEPTH_W-1:0] depth_value;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic wr_depth;
    logic wr_rgb;
    logic tick_start;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic rd_en;
    logic load_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic out_free;
  } status_t;

  // A screen size of zero acts as one, and sizes above the maximum saturate.
  function automatic logic [DIM_W-1:0] screen_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(SCREEN_MAX)) begin
      r = DIM_W'(SCREEN_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // An overlay size of zero acts as one.
  function automatic logic [DIM_W-1:0] nonzero(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

endpackage

[rtl/depth_rgb_scaler_compositor_unit.sv]
// ----------------------------------------------------------------------------
// depth_rgb_scaler_compositor_unit
// Composites a nearest-neighbor scaled depth image with a picture-in-picture
// camera overlay and emits screen pixels in raster order.
// ----------------------------------------------------------------------------
// Depth samples (tuser 0) and camera pixels (tuser 1) are written into two
// 640x480 stores; in BGRA or RGB565 mode a render tick (tuser 2) produces
// the next screen pixel with its framebuffer byte offset, and no item is
// taken until it is loaded into the output register. Most of that work is two
// 10-step divisions on the shared sequential divider that scale the screen
// position to the source. The result waits in an output register, so store
// writes are still accepted while it is pending. After reset the camera store
// is cleared to zero, one entry per cycle; no item is accepted during that
// pass, while register writes are. Registers may be written only when the
// block is idle with no result pending.
module depth_rgb_scaler_compositor_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_index[18:0], depth_value[34:19], red[42:35], green[50:43],
  // blue[58:51], zero fill[63:59]
  input  logic [drsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [drsc_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // byte_address[25:0], pixel_word[57:26], zero fill[63:58]
  output logic [drsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_end
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drsc_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [drsc_pkg::DIM_W-1:0]       cfg_data
);

  logic [drsc_pkg::DIM_W-1:0]  reg_screen_w;
  logic [drsc_pkg::DIM_W-1:0]  reg_screen_h;
  logic [drsc_pkg::MODE_W-1:0] reg_mode;
  logic [drsc_pkg::DIM_W-1:0]  reg_overlay_w;
  logic [drsc_pkg::DIM_W-1:0]  reg_overlay_h;

  drsc_pkg::cfg_t              cfg;
  drsc_pkg::item_t             item;
  drsc_pkg::cmd_t              cmd;
  drsc_pkg::status_t           st;
  logic [drsc_pkg::ADR_W-1:0]  out_addr;
  logic [drsc_pkg::WORD_W-1:0] out_word;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_screen_w  <= drsc_pkg::RST_SCREEN_W;
      reg_screen_h  <= drsc_pkg::RST_SCREEN_H;
      reg_mode      <= drsc_pkg::MODE_BGRA;
      reg_overlay_w <= drsc_pkg::RST_OVERLAY_W;
      reg_overlay_h <= drsc_pkg::RST_OVERLAY_H;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        drsc_pkg::REG_SCREEN_W:  reg_screen_w  <= cfg_data;
        drsc_pkg::REG_SCREEN_H:  reg_screen_h  <= cfg_data;
        drsc_pkg::REG_MODE:      reg_mode      <= cfg_data[drsc_pkg::MODE_W-1:0];
        drsc_pkg::REG_OVERLAY_W: reg_overlay_w <= cfg_data;
        drsc_pkg::REG_OVERLAY_H: reg_overlay_h <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective sizes: zero acts as one, screen sizes saturate.
  assign cfg.w    = drsc_pkg::screen_dim(reg_screen_w);
  assign cfg.h    = drsc_pkg::screen_dim(reg_screen_h);
  assign cfg.ow   = drsc_pkg::nonzero(reg_overlay_w);
  assign cfg.oh   = drsc_pkg::nonzero(reg_overlay_h);
  assign cfg.mode = reg_mode;

  // Input item unpacking.
  assign item.kind        = s_axis_tuser;
  assign item.pixel_index = s_axis_tdata[18:0];
  assign item.depth_value = s_axis_tdata[34:19];
  assign item.red         = s_axis_tdata[42:35];
  assign item.green       = s_axis_tdata[50:43];
  assign item.blue        = s_axis_tdata[58:51];

  drsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .kind    (s_axis_tuser),
    .mode    (reg_mode),
    .st      (st),
    .cmd     (cmd),
    .s_ready (s_axis_tready)
  );

  drsc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg       (cfg),
    .item      (item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_addr  (out_addr),
    .out_word  (out_word),
    .out_last  (m_axis_tlast)
  );

  // Result item packing.
  assign m_axis_tdata = {
    {(drsc_pkg::OUT_TDATA_W - drsc_pkg::WORD_W - drsc_pkg::ADR_W){1'b0}},
    out_word,
    out_addr
  };

`ifndef SYNTHESIS
  // A render tick that produces a pixel keeps the block busy afterwards.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == drsc_pkg::KIND_TICK &&
    (reg_mode == drsc_pkg::MODE_BGRA || reg_mode == drsc_pkg::MODE_RGB565)
    |=> !s_axis_tready)
    else $error("render tick accepted without leaving idle");

  // BGRA pixels carry full alpha.
  a_bgra_alpha: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && reg_mode == drsc_pkg::MODE_BGRA |-> m_axis_tdata[57:50] == 8'hFF)
    else $error("BGRA pixel without full alpha");

  // RGB565 pixels leave the upper half of the word clear.
  a_565_upper: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && reg_mode == drsc_pkg::MODE_RGB565 |-> m_axis_tdata[57:42] == 16'h0000)
    else $error("RGB565 pixel with upper bits set");

  // The last pixel of a BGRA frame sits at the end of the framebuffer.
  a_frame_end_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && reg_mode == drsc_pkg::MODE_BGRA
    |-> out_addr == drsc_pkg::ADR_W'((drsc_pkg::ADR_W'(cfg.w) *
                                      drsc_pkg::ADR_W'(cfg.h) - 1'b1) << 2))
    else $error("frame end flag away from the last framebuffer pixel");
`endif

endmodule

[rtl/drsc_div.sv]
// ----------------------------------------------------------------------------
// drsc_div
// Sequential restoring divider, one quotient bit per cycle. The quotient is
// known to fit in QW bits, so the divisor starts shifted up by QW-1 places.
// ----------------------------------------------------------------------------
module drsc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [drsc_pkg::DVD_W-1:0] dividend,
  input  logic [drsc_pkg::DIM_W-1:0] divisor,
  output logic [drsc_pkg::QW-1:0]    quotient,
  output logic                       done
);

  logic [drsc_pkg::CNT_W-1:0] cnt;
  logic [drsc_pkg::DVD_W-1:0] rem;
  logic [drsc_pkg::DSH_W-1:0] dsh;
  logic [drsc_pkg::QW-1:0]    quo;
  logic                       ge;

  // Trial subtraction of the current divisor multiple.
  assign ge       = rem >= drsc_pkg::DVD_W'(dsh);
  assign quotient = quo;

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= drsc_pkg::CNT_W'(drsc_pkg::QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == drsc_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= {divisor, {(drsc_pkg::QW - 1){1'b0}}};
      quo <= '0;
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= rem - drsc_pkg::DVD_W'(dsh);
      end
      quo <= {quo[drsc_pkg::QW-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

[rtl/drsc_ctrl.sv]
// ----------------------------------------------------------------------------
// drsc_ctrl
// Controller of the compositor: sequences the clearing pass, store writes and
// the steps of a render tick (two divisions, store read, output load).
// ----------------------------------------------------------------------------
module drsc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  input  logic [drsc_pkg::KIND_W-1:0] kind,
  input  logic [drsc_pkg::MODE_W-1:0] mode,
  input  drsc_pkg::status_t           st,
  output drsc_pkg::cmd_t              cmd,
  output logic                        s_ready
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_STX   = 8'b0000_0100,
    ST_WAITX = 8'b0000_1000,
    ST_STY   = 8'b0001_0000,
    ST_WAITY = 8'b0010_0000,
    ST_ADDR  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   mode_ok;

  assign mode_ok = (mode == drsc_pkg::MODE_BGRA) || (mode == drsc_pkg::MODE_RGB565);
  assign s_ready = (state == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid) begin
          if (kind == drsc_pkg::KIND_DEPTH) begin
            cmd.wr_depth = 1'b1;
          end else if (kind == drsc_pkg::KIND_RGB) begin
            cmd.wr_rgb = 1'b1;
          end else if (kind == drsc_pkg::KIND_TICK && mode_ok) begin
            cmd.tick_start = 1'b1;
            state_next     = ST_STX;
          end
        end
      end
      ST_STX: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAITX;
      end
      ST_WAITX: begin
        if (st.div_done) begin
          cmd.cap_x  = 1'b1;
          state_next = ST_STY;
        end
      end
      ST_STY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_next    = ST_WAITY;
      end
      ST_WAITY: begin
        if (st.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/drsc_dpath.sv]
// ----------------------------------------------------------------------------
// drsc_dpath
// Datapath of the compositor: depth and camera stores, raster position,
// overlay window test, shared divider for the scaled source coordinates,
// framebuffer offset and the output register.
// ----------------------------------------------------------------------------
module drsc_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  drsc_pkg::cmd_t              cmd,
  output drsc_pkg::status_t           st,
  input  drsc_pkg::cfg_t              cfg,
  input  drsc_pkg::item_t             item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [drsc_pkg::ADR_W-1:0]  out_addr,
  output logic [drsc_pkg::WORD_W-1:0] out_word,
  output logic                        out_last
);

  // Depth sample to gray level: zero stays black, otherwise 255 - min(255, d/16).
  function automatic logic [drsc_pkg::COLOR_W-1:0] gray_of(
    input logic [drsc_pkg::DEPTH_W-1:0] d
  );
    logic [drsc_pkg::COLOR_W-1:0] g;
    if (d == '0 || d[drsc_pkg::DEPTH_W-1:12] != '0) begin
      g = '0;
    end else begin
      g = ~d[11:4];
    end
    return g;
  endfunction

  localparam int WIN_W = drsc_pkg::DIM_W + 1;

  logic [drsc_pkg::COLOR_W-1:0] depth_mem [drsc_pkg::SRC_PIXELS];
  logic [drsc_pkg::RGB_W-1:0]   cam_mem   [drsc_pkg::SRC_PIXELS];
  logic [drsc_pkg::COLOR_W-1:0] depth_rdata;
  logic [drsc_pkg::RGB_W-1:0]   cam_rdata;

  logic [drsc_pkg::ADDR_W-1:0]  clr_addr;
  logic [drsc_pkg::POS_W-1:0]   raster_col;
  logic [drsc_pkg::POS_W-1:0]   raster_row;
  logic [drsc_pkg::QW-1:0]      sx;
  logic [drsc_pkg::QW-1:0]      sy;
  logic [drsc_pkg::ADR_W-1:0]   lin;

  logic                         in_range;
  logic [drsc_pkg::ADDR_W-1:0]  wr_addr;
  logic                         cam_we;
  logic [drsc_pkg::ADDR_W-1:0]  cam_waddr;
  logic [drsc_pkg::RGB_W-1:0]   cam_wdata;
  logic [drsc_pkg::ADDR_W-1:0]  rd_addr;

  logic [drsc_pkg::DIM_W-1:0]   col_ext;
  logic [drsc_pkg::DIM_W-1:0]   row_ext;
  logic                         restart;
  logic [WIN_W-1:0]             tx;
  logic [WIN_W-1:0]             ty;
  logic                         in_win;
  logic [drsc_pkg::DIM_W-1:0]   pos_x;
  logic [drsc_pkg::DIM_W-1:0]   pos_y;
  logic [drsc_pkg::DVD_W-1:0]   dvd;
  logic [drsc_pkg::DIM_W-1:0]   dvs;
  logic [drsc_pkg::QW-1:0]      quotient;
  logic                         div_done;

  logic [drsc_pkg::COLOR_W-1:0] r;
  logic [drsc_pkg::COLOR_W-1:0] g;
  logic [drsc_pkg::COLOR_W-1:0] b;
  logic [drsc_pkg::WORD_W-1:0]  word;
  logic [drsc_pkg::ADR_W-1:0]   baddr;
  logic                         last;

  // Store writes: input items, or zeros during the clearing pass.
  assign in_range  = 32'(item.pixel_index) < 32'(drsc_pkg::SRC_PIXELS);
  assign wr_addr   = drsc_pkg::ADDR_W'(item.pixel_index);
  assign cam_we    = cmd.clear || (cmd.wr_rgb && in_range);
  assign cam_waddr = cmd.clear ? clr_addr : wr_addr;
  assign cam_wdata = cmd.clear ? '0 : {item.red, item.green, item.blue};

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign st.clr_last = (clr_addr == drsc_pkg::ADDR_W'(drsc_pkg::SRC_PIXELS - 1));

  // Depth store.
  always_ff @(posedge clk) begin
    if (cmd.wr_depth && in_range) begin
      depth_mem[wr_addr] <= gray_of(item.depth_value);
    end
    if (cmd.rd_en) begin
      depth_rdata <= depth_mem[rd_addr];
    end
  end

  // Camera store.
  always_ff @(posedge clk) begin
    if (cam_we) begin
      cam_mem[cam_waddr] <= cam_wdata;
    end
    if (cmd.rd_en) begin
      cam_rdata <= cam_mem[rd_addr];
    end
  end

  // Raster position and the check that it still lies on the screen.
  assign col_ext = drsc_pkg::DIM_W'(raster_col);
  assign row_ext = drsc_pkg::DIM_W'(raster_row);
  assign restart = (col_ext >= cfg.w) || (row_ext >= cfg.h);

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_col <= '0;
      raster_row <= '0;
    end else if (cmd.tick_start && restart) begin
      raster_col <= '0;
      raster_row <= '0;
    end else if (cmd.load_out) begin
      if (col_ext + 1'b1 < cfg.w) begin
        raster_col <= raster_col + 1'b1;
      end else begin
        raster_col <= '0;
        raster_row <= (row_ext + 1'b1 < cfg.h) ? raster_row + 1'b1 : '0;
      end
    end
  end

  // Overlay window anchored bottom right: inside when p + win >= screen,
  // and the local position is p + win - screen.
  assign tx     = WIN_W'(raster_col) + WIN_W'(cfg.ow);
  assign ty     = WIN_W'(raster_row) + WIN_W'(cfg.oh);
  assign in_win = (tx >= WIN_W'(cfg.w)) && (ty >= WIN_W'(cfg.h));
  assign pos_x  = in_win ? drsc_pkg::DIM_W'(tx - WIN_W'(cfg.w)) : col_ext;
  assign pos_y  = in_win ? drsc_pkg::DIM_W'(ty - WIN_W'(cfg.h)) : row_ext;

  // Divider operands. The position is always below the divisor, so the
  // quotient stays inside the source frame and needs no clamp.
  always_comb begin
    if (cmd.div_sel_y) begin
      dvd = drsc_pkg::DVD_W'(pos_y) * drsc_pkg::DVD_W'(drsc_pkg::SRC_HEIGHT);
      dvs = in_win ? cfg.oh : cfg.h;
    end else begin
      dvd = drsc_pkg::DVD_W'(pos_x) * drsc_pkg::DVD_W'(drsc_pkg::SRC_WIDTH);
      dvs = in_win ? cfg.ow : cfg.w;
    end
  end

  drsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quotient),
    .done     (div_done)
  );

  assign st.div_done = div_done;

  // Scaled source coordinates.
  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      sx <= quotient;
    end
    if (cmd.cap_y) begin
      sy <= quotient;
    end
  end

  assign rd_addr = drsc_pkg::ADDR_W'(drsc_pkg::ADDR_W'(sy) *
                                     drsc_pkg::ADDR_W'(drsc_pkg::SRC_WIDTH)) +
                   drsc_pkg::ADDR_W'(sx);

  // Linear screen index, registered alongside the store read.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      lin <= drsc_pkg::ADR_W'(drsc_pkg::ADR_W'(raster_row) * drsc_pkg::ADR_W'(cfg.w)) +
             drsc_pkg::ADR_W'(raster_col);
    end
  end

  // Pixel selection and formatting.
  always_comb begin
    if (in_win) begin
      r = cam_rdata[23:16];
      g = cam_rdata[15:8];
      b = cam_rdata[7:0];
    end else begin
      r = depth_rdata;
      g = depth_rdata;
      b = depth_rdata;
    end
    if (cfg.mode == drsc_pkg::MODE_BGRA) begin
      word  = {8'hFF, r, g, b};
      baddr = drsc_pkg::ADR_W'({lin, 2'b00});
    end else begin
      word  = {16'h0000, r[7:3], g[7:2], b[7:3]};
      baddr = drsc_pkg::ADR_W'({lin, 1'b0});
    end
  end

  assign last = (col_ext == cfg.w - 1'b1) && (row_ext == cfg.h - 1'b1);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr <= baddr;
      out_word <= word;
      out_last <= last;
    end
  end

  assign st.out_free = !out_valid || out_ready;

endmodule
